[sv/scic_pkg.sv]
package scic_pkg;

   localparam int COORD_W   = 32;
   localparam int DIFF_W    = 33;
   localparam int RAD_W     = 31;
   localparam int TAG_W     = 16;
   localparam int A_W       = 66;
   localparam int H_W       = 67;
   localparam int R2_W      = 62;
   localparam int DISC_W    = 128;
   localparam int ROOT_W    = 64;
   localparam int SQ_REM_W  = 66;
   localparam int N_W       = 68;
   localparam int DIV_REM_W = 67;
   localparam int SQ_CELLS  = DISC_W / 2;

   localparam int T_FRAC_BITS_DEF = 24;

   // geometry that travels alongside the arithmetic
   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
      logic [TAG_W-1:0]          tag;
      logic [A_W-1:0]            a;
      logic signed [H_W-1:0]     h;
   } item_type;

endpackage

[sv/segment_circle_intersect.sv]
// throughput: one request per cycle while not stalled; a request with two points holds the output
// register until both points are taken, and the pipeline stalls only while its last stage holds
// a result with points and waits on a busy output register
// depth is set by the 64-cell square root chain and the T_FRAC_BITS+1 cell divider chains
// reset clears all valid flags and the output count; data registers are not reset
module segment_circle_intersect #(
   parameter int T_FRAC_BITS = scic_pkg::T_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [scic_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [scic_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [scic_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [scic_pkg::COORD_W-1:0] req_end_y,
   input  logic signed [scic_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [scic_pkg::COORD_W-1:0] req_center_y,
   input  logic [scic_pkg::RAD_W-1:0]          req_radius,
   input  logic [scic_pkg::TAG_W-1:0]          req_segment_tag,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [scic_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [scic_pkg::COORD_W-1:0] rsp_point_y,
   output logic [scic_pkg::TAG_W-1:0]          rsp_point_tag,
   output logic                                rsp_last_point
);

   localparam int CW  = scic_pkg::COORD_W;
   localparam int DW  = scic_pkg::DIFF_W;
   localparam int AW  = scic_pkg::A_W;
   localparam int HW  = scic_pkg::H_W;
   localparam int NW  = scic_pkg::N_W;
   localparam int XW  = scic_pkg::DISC_W;
   localparam int DFW = 2 * AW + 1;
   localparam int NSQ = scic_pkg::SQ_CELLS;
   localparam int QW  = T_FRAC_BITS + 1;
   localparam int PW  = QW + 1 + DW;

   logic en;
   logic has_res;
   logic rsp_fire;
   logic em_free;

   // stage 1: differences
   logic                      s1_v_ff;
   logic signed [DW-1:0]      s1_dx_ff, s1_dy_ff, s1_fx_ff, s1_fy_ff;
   logic signed [CW-1:0]      s1_sx_ff, s1_sy_ff;
   logic [scic_pkg::RAD_W-1:0] s1_rad_ff;
   logic [scic_pkg::TAG_W-1:0] s1_tag_ff;

   // stage 2: products
   logic                      s2_v_ff;
   logic signed [2*DW-1:0]    s2_dx2_ff, s2_dy2_ff, s2_fxdx_ff, s2_fydy_ff;
   logic signed [2*DW-1:0]    s2_fxdy_ff, s2_fydx_ff;
   logic [scic_pkg::R2_W-1:0] s2_r2_ff;
   logic signed [CW-1:0]      s2_sx_ff, s2_sy_ff;
   logic signed [DW-1:0]      s2_dx_ff, s2_dy_ff;
   logic [scic_pkg::TAG_W-1:0] s2_tag_ff;

   // stage 3: a, h and cross product
   logic                      s3_v_ff;
   scic_pkg::item_type        s3_item_ff;
   logic signed [HW-1:0]      s3_cross_ff;
   logic [scic_pkg::R2_W-1:0] s3_r2_ff;

   // stage 4: operands of the wide products
   logic                      s4_v_ff;
   scic_pkg::item_type        s4_item_ff;
   logic [AW-1:0]             s4_cmag_ff;
   logic [scic_pkg::R2_W-1:0] s4_r2_ff;
   logic                      s4_anz_ff;

   logic [AW+scic_pkg::R2_W-1:0] ar2;
   logic [2*AW-1:0]              cr2;

   logic                      s5_v_ff, s6_v_ff;
   scic_pkg::item_type        s5_item_ff, s6_item_ff;
   logic                      s5_anz_ff, s6_anz_ff;

   // discriminant as a*r^2 - cross^2
   logic signed [DFW-1:0]     disc;

   logic                      sq_v_ff    [0:NSQ];
   logic                      sq_live_ff [0:NSQ];
   scic_pkg::item_type        sq_item_ff [0:NSQ];
   logic [XW-1:0]             sq_d0_ff;
   logic [XW-1:0]             sq_d    [0:NSQ];
   logic [scic_pkg::SQ_REM_W-1:0] sq_rem  [0:NSQ];
   logic [scic_pkg::ROOT_W-1:0]   sq_root [0:NSQ];

   logic                      r1_v_ff, r1_live_ff, r1_snz_ff;
   scic_pkg::item_type        r1_item_ff;
   logic signed [NW-1:0]      r1_n1_ff, r1_n2_ff;

   logic                      dv_v_ff    [0:QW];
   logic                      dv_ok1_ff  [0:QW];
   logic                      dv_ok2_ff  [0:QW];
   scic_pkg::item_type        dv_item_ff [0:QW];
   logic [AW-1:0]             dv_n_ff    [0:1];
   logic [scic_pkg::DIV_REM_W-1:0] dv_rem [0:1][0:QW];
   logic [QW-1:0]             dv_q       [0:1][0:QW];

   logic                      p1_v_ff, p1_ok1_ff, p1_ok2_ff;
   logic signed [CW-1:0]      p1_sx_ff, p1_sy_ff;
   logic [scic_pkg::TAG_W-1:0] p1_tag_ff;
   logic signed [PW-1:0]      p1_px_ff [0:1];
   logic signed [PW-1:0]      p1_py_ff [0:1];

   logic                      lst_v_ff, lst_ok1_ff, lst_ok2_ff;
   logic signed [CW-1:0]      lst_x_ff [0:1];
   logic signed [CW-1:0]      lst_y_ff [0:1];
   logic [scic_pkg::TAG_W-1:0] lst_tag_ff;

   logic [1:0]                em_cnt_ff;
   logic signed [CW-1:0]      em_x0_ff, em_y0_ff, em_x1_ff, em_y1_ff;
   logic [scic_pkg::TAG_W-1:0] em_tag_ff;

   // the whole row moves together; it stops only when a request with points
   // reaches the end while the output register is still busy
   always_comb begin
      has_res   = lst_v_ff & (lst_ok1_ff | lst_ok2_ff);
      rsp_fire  = rsp_valid & ~rsp_stall;
      em_free   = (em_cnt_ff == 2'd0) | ((em_cnt_ff == 2'd1) & rsp_fire);
      en        = ~has_res | em_free;
      req_stall = ~en;
      disc      = $signed({{(DFW-AW-scic_pkg::R2_W){1'b0}}, ar2}) - $signed({1'b0, cr2});
   end

   scic_mul #(.WA(AW), .WB(scic_pkg::R2_W)) u_mul_ar2 (
      .clock (clock),
      .en    (en),
      .a     (s4_item_ff.a),
      .b     (s4_r2_ff),
      .p     (ar2)
   );

   scic_mul #(.WA(AW), .WB(AW)) u_mul_cr2 (
      .clock (clock),
      .en    (en),
      .a     (s4_cmag_ff),
      .b     (s4_cmag_ff),
      .p     (cr2)
   );

   assign sq_d[0]    = sq_d0_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
      scic_sqrt_cell u_cell (
         .clock    (clock),
         .en       (en),
         .d_in     (sq_d[i]),
         .rem_in   (sq_rem[i]),
         .root_in  (sq_root[i]),
         .d_out    (sq_d[i+1]),
         .rem_out  (sq_rem[i+1]),
         .root_out (sq_root[i+1])
      );
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      assign dv_rem[l][0] = {1'b0, dv_n_ff[l]};
      assign dv_q[l][0]   = '0;
      for (genvar j = 0; j < QW; j++) begin : g_div
         scic_div_cell #(.QW(QW)) u_cell (
            .clock   (clock),
            .en      (en),
            .a_in    (dv_item_ff[j].a),
            .rem_in  (dv_rem[l][j]),
            .q_in    (dv_q[l][j]),
            .rem_out (dv_rem[l][j+1]),
            .q_out   (dv_q[l][j+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         for (int i = 0; i <= NSQ; i++) sq_v_ff[i] <= 1'b0;
         r1_v_ff  <= 1'b0;
         for (int j = 0; j <= QW; j++) dv_v_ff[j] <= 1'b0;
         p1_v_ff  <= 1'b0;
         lst_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff    <= req_valid;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         s4_v_ff    <= s3_v_ff;
         s5_v_ff    <= s4_v_ff;
         s6_v_ff    <= s5_v_ff;
         sq_v_ff[0] <= s6_v_ff;
         for (int i = 1; i <= NSQ; i++) sq_v_ff[i] <= sq_v_ff[i-1];
         r1_v_ff    <= sq_v_ff[NSQ];
         dv_v_ff[0] <= r1_v_ff;
         for (int j = 1; j <= QW; j++) dv_v_ff[j] <= dv_v_ff[j-1];
         p1_v_ff    <= dv_v_ff[QW];
         lst_v_ff   <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff  <= DW'(req_end_x) - DW'(req_start_x);
         s1_dy_ff  <= DW'(req_end_y) - DW'(req_start_y);
         s1_fx_ff  <= DW'(req_start_x) - DW'(req_center_x);
         s1_fy_ff  <= DW'(req_start_y) - DW'(req_center_y);
         s1_sx_ff  <= req_start_x;
         s1_sy_ff  <= req_start_y;
         s1_rad_ff <= req_radius;
         s1_tag_ff <= req_segment_tag;

         s2_dx2_ff  <= s1_dx_ff * s1_dx_ff;
         s2_dy2_ff  <= s1_dy_ff * s1_dy_ff;
         s2_fxdx_ff <= s1_fx_ff * s1_dx_ff;
         s2_fydy_ff <= s1_fy_ff * s1_dy_ff;
         s2_fxdy_ff <= s1_fx_ff * s1_dy_ff;
         s2_fydx_ff <= s1_fy_ff * s1_dx_ff;
         s2_r2_ff   <= s1_rad_ff * s1_rad_ff;
         s2_sx_ff   <= s1_sx_ff;
         s2_sy_ff   <= s1_sy_ff;
         s2_dx_ff   <= s1_dx_ff;
         s2_dy_ff   <= s1_dy_ff;
         s2_tag_ff  <= s1_tag_ff;

         s3_item_ff.sx  <= s2_sx_ff;
         s3_item_ff.sy  <= s2_sy_ff;
         s3_item_ff.dx  <= s2_dx_ff;
         s3_item_ff.dy  <= s2_dy_ff;
         s3_item_ff.tag <= s2_tag_ff;
         s3_item_ff.a   <= AW'(HW'(s2_dx2_ff) + HW'(s2_dy2_ff));
         s3_item_ff.h   <= HW'(s2_fxdx_ff) + HW'(s2_fydy_ff);
         s3_cross_ff    <= HW'(s2_fxdy_ff) - HW'(s2_fydx_ff);
         s3_r2_ff       <= s2_r2_ff;

         s4_item_ff <= s3_item_ff;
         s4_cmag_ff <= s3_cross_ff[HW-1] ? AW'(-s3_cross_ff) : AW'(s3_cross_ff);
         s4_r2_ff   <= s3_r2_ff;
         s4_anz_ff  <= |s3_item_ff.a;

         s5_item_ff <= s4_item_ff;
         s5_anz_ff  <= s4_anz_ff;
         s6_item_ff <= s5_item_ff;
         s6_anz_ff  <= s5_anz_ff;

         sq_d0_ff      <= disc[XW-1:0];
         sq_live_ff[0] <= s6_anz_ff & ~disc[DFW-1];
         sq_item_ff[0] <= s6_item_ff;
         for (int i = 1; i <= NSQ; i++) begin
            sq_live_ff[i] <= sq_live_ff[i-1];
            sq_item_ff[i] <= sq_item_ff[i-1];
         end

         // numerators -h - s and -h + s
         r1_item_ff <= sq_item_ff[NSQ];
         r1_live_ff <= sq_live_ff[NSQ];
         r1_snz_ff  <= |sq_root[NSQ];
         r1_n1_ff   <= -NW'(sq_item_ff[NSQ].h) - NW'(sq_root[NSQ]);
         r1_n2_ff   <= -NW'(sq_item_ff[NSQ].h) + NW'(sq_root[NSQ]);

         // a root counts only when 0 <= n <= a
         dv_item_ff[0] <= r1_item_ff;
         dv_ok1_ff[0]  <= r1_live_ff & ~r1_n1_ff[NW-1]
                          & (r1_n1_ff[NW-2:0] <= (NW-1)'(r1_item_ff.a));
         dv_ok2_ff[0]  <= r1_live_ff & r1_snz_ff & ~r1_n2_ff[NW-1]
                          & (r1_n2_ff[NW-2:0] <= (NW-1)'(r1_item_ff.a));
         dv_n_ff[0]    <= r1_n1_ff[AW-1:0];
         dv_n_ff[1]    <= r1_n2_ff[AW-1:0];
         for (int j = 1; j <= QW; j++) begin
            dv_item_ff[j] <= dv_item_ff[j-1];
            dv_ok1_ff[j]  <= dv_ok1_ff[j-1];
            dv_ok2_ff[j]  <= dv_ok2_ff[j-1];
         end

         p1_ok1_ff <= dv_ok1_ff[QW];
         p1_ok2_ff <= dv_ok2_ff[QW];
         p1_sx_ff  <= dv_item_ff[QW].sx;
         p1_sy_ff  <= dv_item_ff[QW].sy;
         p1_tag_ff <= dv_item_ff[QW].tag;
         for (int l = 0; l < 2; l++) begin
            p1_px_ff[l] <= $signed({1'b0, dv_q[l][QW]}) * dv_item_ff[QW].dx;
            p1_py_ff[l] <= $signed({1'b0, dv_q[l][QW]}) * dv_item_ff[QW].dy;
         end

         // floor(t*d / 2^T) is the arithmetic shift of the product
         lst_ok1_ff <= p1_ok1_ff;
         lst_ok2_ff <= p1_ok2_ff;
         lst_tag_ff <= p1_tag_ff;
         for (int l = 0; l < 2; l++) begin
            lst_x_ff[l] <= p1_sx_ff + p1_px_ff[l][T_FRAC_BITS +: CW];
            lst_y_ff[l] <= p1_sy_ff + p1_py_ff[l][T_FRAC_BITS +: CW];
         end
      end
   end

   // output register: slot 0 is always the point on the port
   always_ff @(posedge clock) begin
      if (reset) begin
         em_cnt_ff <= 2'd0;
      end else if (en & has_res) begin
         em_cnt_ff <= {lst_ok1_ff & lst_ok2_ff, lst_ok1_ff ^ lst_ok2_ff};
      end else if (rsp_fire) begin
         em_cnt_ff <= em_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (en & has_res) begin
         em_x0_ff  <= lst_ok1_ff ? lst_x_ff[0] : lst_x_ff[1];
         em_y0_ff  <= lst_ok1_ff ? lst_y_ff[0] : lst_y_ff[1];
         em_x1_ff  <= lst_x_ff[1];
         em_y1_ff  <= lst_y_ff[1];
         em_tag_ff <= lst_tag_ff;
      end else if (rsp_fire) begin
         em_x0_ff <= em_x1_ff;
         em_y0_ff <= em_y1_ff;
      end
   end

   assign rsp_valid      = em_cnt_ff != 2'd0;
   assign rsp_point_x    = em_x0_ff;
   assign rsp_point_y    = em_y0_ff;
   assign rsp_point_tag  = em_tag_ff;
   assign rsp_last_point = em_cnt_ff == 2'd1;

`ifndef SYNTHESIS
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> lst_v_ff && (lst_ok1_ff || lst_ok2_ff) && em_cnt_ff != 2'd0)
      else $error("request stalled without a blocked result");

   a_second_point_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_point
      |=> rsp_valid && rsp_last_point && $stable(rsp_point_tag))
      else $error("second point of a segment missing or tag changed");

   a_stall_freezes_end: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> lst_v_ff && $stable(lst_tag_ff))
      else $error("last stage moved while stalled");
`endif

endmodule

[sv/scic_mul.sv]
module scic_mul #(
   parameter int WA = scic_pkg::A_W,
   parameter int WB = scic_pkg::A_W
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WA-1:0]    a,
   input  logic [WB-1:0]    b,
   output logic [WA+WB-1:0] p
);

   localparam int LA = WA / 2;
   localparam int UA = WA - LA;
   localparam int LB = WB / 2;
   localparam int UB = WB - LB;
   localparam int WP = WA + WB;

   logic [LA+LB-1:0] ll_ff;
   logic [LA+UB-1:0] lh_ff;
   logic [UA+LB-1:0] hl_ff;
   logic [UA+UB-1:0] hh_ff;
   logic [WP-1:0]    p_ff;

   // partial products first, then one merge
   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= a[LA-1:0]  * b[LB-1:0];
         lh_ff <= a[LA-1:0]  * b[WB-1:LB];
         hl_ff <= a[WA-1:LA] * b[LB-1:0];
         hh_ff <= a[WA-1:LA] * b[WB-1:LB];
         p_ff  <= WP'(ll_ff) + (WP'(lh_ff) << LB) + (WP'(hl_ff) << LA)
                  + (WP'(hh_ff) << (LA + LB));
      end
   end

   assign p = p_ff;

endmodule

[sv/scic_sqrt_cell.sv]
module scic_sqrt_cell (
   input  logic                          clock,
   input  logic                          en,
   input  logic [scic_pkg::DISC_W-1:0]   d_in,
   input  logic [scic_pkg::SQ_REM_W-1:0] rem_in,
   input  logic [scic_pkg::ROOT_W-1:0]   root_in,
   output logic [scic_pkg::DISC_W-1:0]   d_out,
   output logic [scic_pkg::SQ_REM_W-1:0] rem_out,
   output logic [scic_pkg::ROOT_W-1:0]   root_out
);

   localparam int DW = scic_pkg::DISC_W;
   localparam int RW = scic_pkg::SQ_REM_W;
   localparam int QW = scic_pkg::ROOT_W;

   logic [DW-1:0] d_ff;
   logic [RW-1:0] rem_ff;
   logic [QW-1:0] root_ff;
   logic [RW-1:0] rem_sh;
   logic [RW-1:0] trial;
   logic [RW-1:0] rem_in_n;
   logic          ge;

   // one root bit per cell: bring down two radicand bits, try 4q+1
   always_comb begin
      rem_sh   = {rem_in[RW-3:0], d_in[DW-1 -: 2]};
      trial    = {root_in, 2'b01};
      ge       = rem_sh >= trial;
      rem_in_n = ge ? rem_sh - trial : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in << 2;
         rem_ff  <= rem_in_n;
         root_ff <= {root_in[QW-2:0], ge};
      end
   end

   assign d_out    = d_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

[sv/scic_div_cell.sv]
module scic_div_cell #(
   parameter int QW = scic_pkg::T_FRAC_BITS_DEF + 1
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [scic_pkg::A_W-1:0]       a_in,
   input  logic [scic_pkg::DIV_REM_W-1:0] rem_in,
   input  logic [QW-1:0]                  q_in,
   output logic [scic_pkg::DIV_REM_W-1:0] rem_out,
   output logic [QW-1:0]                  q_out
);

   localparam int RW = scic_pkg::DIV_REM_W;

   logic [RW-1:0] rem_ff;
   logic [QW-1:0] q_ff;
   logic [RW-1:0] den;
   logic [RW-1:0] rem_in_n;
   logic          ge;

   // restoring step: one quotient bit, remainder stays below the divisor
   always_comb begin
      den      = {1'b0, a_in};
      ge       = rem_in >= den;
      rem_in_n = ge ? rem_in - den : rem_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= {rem_in_n[RW-2:0], 1'b0};
         q_ff   <= {q_in[QW-2:0], ge};
      end
   end

   assign rem_out = rem_ff;
   assign q_out   = q_ff;

endmodule
